FILE: src/camera_ray_direction_core_macros.svh
// assertion macros used by the ray direction core
`ifndef CAMERA_RAY_DIRECTION_CORE_MACROS_SVH
`define CAMERA_RAY_DIRECTION_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define CRD_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the following cycle
`define CRD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/crd_pkg.sv
package crd_pkg;

   localparam int MaxDim = 4096;
   localparam int DimW = $clog2(MaxDim) + 1;
   localparam int PixW = 12;
   localparam int JitW = 8;
   localparam int CoefW = 16;
   localparam int RowW = 48;
   localparam int FocW = 24;
   localparam int CsrW = 48;
   localparam int CsrIdxW = 3;
   localparam int VecW = 26;
   localparam int ProdW = VecW + CoefW;
   localparam int RotW = ProdW + 2;
   localparam int MagW = RotW;
   localparam int NrmW = 31;
   localparam int SumW = 64;
   localparam int RootW = 32;
   localparam int DirW = 16;
   localparam int QuoW = 15;
   // scaled magnitude plus half the norm can carry into one more bit
   localparam int QuoNumW = NrmW + 15;
   // sqrt cells: one result bit each
   localparam int SqrtCells = RootW;
   // divide cells: one quotient bit each
   localparam int DivCells = QuoW;

   localparam logic [CsrIdxW-1:0] RegRowX = 3'd0;
   localparam logic [CsrIdxW-1:0] RegRowY = 3'd1;
   localparam logic [CsrIdxW-1:0] RegRowZ = 3'd2;
   localparam logic [CsrIdxW-1:0] RegFocal = 3'd3;
   localparam logic [CsrIdxW-1:0] RegWidth = 3'd4;
   localparam logic [CsrIdxW-1:0] RegHeight = 3'd5;

   typedef struct packed {
      logic [PixW-1:0] pixel_x;
      logic [PixW-1:0] pixel_y;
      logic [JitW-1:0] jitter_x;
      logic [JitW-1:0] jitter_y;
   } req_type;

   typedef struct packed {
      logic signed [DirW-1:0] dir_x;
      logic signed [DirW-1:0] dir_y;
      logic signed [DirW-1:0] dir_z;
      logic degenerate;
   } rsp_type;

   // data carried along the sqrt cells
   typedef struct packed {
      logic [SumW-1:0] rem;
      logic [RootW-1:0] root;
      logic [2:0][NrmW-1:0] mag;
      logic [2:0] neg;
      logic degen;
   } sqrt_word_type;

   // data carried along the divide cells
   typedef struct packed {
      logic [2:0][QuoNumW-1:0] rem;
      logic [2:0][QuoW-1:0] quo;
      logic [RootW-1:0] den;
      logic [2:0] neg;
      logic degen;
   } div_word_type;

endpackage

FILE: src/crd_sqrt_cell.sv
module crd_sqrt_cell
   import crd_pkg::*;
(
   input  logic clock,
   input  logic stall,
   input  logic [5:0] shift,
   input  sqrt_word_type word_in,
   output sqrt_word_type word_out
);
   sqrt_word_type word_ff, word_in_c;
   logic [SumW-1:0] trial;

   always_comb begin
      word_in_c = word_in;
      // restoring sqrt step on the bit pair at this cell's weight
      trial = {{(SumW-RootW-2){1'b0}}, word_in.root, 2'b01} << shift;
      if (word_in.rem >= trial) begin
         word_in_c.rem = word_in.rem - trial;
         word_in_c.root = {word_in.root[RootW-2:0], 1'b1};
      end else begin
         word_in_c.root = {word_in.root[RootW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) word_ff <= word_in_c;
   end

   assign word_out = word_ff;
endmodule

FILE: src/crd_div_cell.sv
module crd_div_cell
   import crd_pkg::*;
(
   input  logic clock,
   input  logic stall,
   input  logic [3:0] shift,
   input  div_word_type word_in,
   output div_word_type word_out
);
   div_word_type word_ff, word_in_c;
   logic [QuoNumW+QuoW-1:0] sub;

   always_comb begin
      word_in_c = word_in;
      sub = {{(QuoNumW+QuoW-RootW){1'b0}}, word_in.den} << shift;
      for (int i = 0; i < 3; i++) begin
         if ({{QuoW{1'b0}}, word_in.rem[i]} >= sub) begin
            word_in_c.rem[i] = word_in.rem[i] - sub[QuoNumW-1:0];
            word_in_c.quo[i] = word_in.quo[i] | (QuoW'(1) << shift);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) word_ff <= word_in_c;
   end

   assign word_out = word_ff;
endmodule

FILE: src/camera_ray_direction_core.sv
// channel | ports          | word
// request | req_valid/stall | req_type pixel and jitter
// result  | rsp_valid/stall | rsp_type direction and flag
// one word per cycle while the result is not stalled; pipeline: 6 setup stages, 32 sqrt cells,
// 15 divide cells and the output register
// the whole pipeline moves as one: a stalled result holds every stage
// reset clears valid bits and loads register defaults, payload stages are not reset
module camera_ray_direction_core
   import crd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_data,
   input  logic csr_write,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrW-1:0] csr_wdata
);
   `include "camera_ray_direction_core_macros.svh"

   localparam int Depth = 6 + SqrtCells + DivCells + 1;

   logic [RowW-1:0] row_ff [3];
   logic [FocW-1:0] focal_ff;
   logic [DimW-1:0] width_ff, height_ff;
   logic [Depth-1:0] valid_ff, valid_in;
   logic adv;

   // pipeline advances unless the output word is held
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign valid_in = {valid_ff[Depth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= RowW'(64'd16384);
         row_ff[1] <= RowW'(64'd1073741824);
         row_ff[2] <= RowW'(64'd70368744177664);
         focal_ff <= FocW'(65536);
         width_ff <= DimW'(512);
         height_ff <= DimW'(512);
         valid_ff <= '0;
      end else begin
         if (adv) valid_ff <= valid_in;
         if (csr_write) begin
            case (csr_index)
               RegRowX: row_ff[0] <= csr_wdata[RowW-1:0];
               RegRowY: row_ff[1] <= csr_wdata[RowW-1:0];
               RegRowZ: row_ff[2] <= csr_wdata[RowW-1:0];
               RegFocal: focal_ff <= csr_wdata[FocW-1:0];
               RegWidth: width_ff <= csr_wdata[DimW-1:0];
               RegHeight: height_ff <= csr_wdata[DimW-1:0];
               default: ;
            endcase
         end
      end
   end

   // stage 1: clamp and form image-plane vector
   logic [DimW-1:0] w_c, h_c;
   logic [PixW-1:0] x_c, y_c;
   logic signed [VecW-1:0] v_ff [3], v_in [3];
   always_comb begin
      w_c = (width_ff == '0) ? DimW'(1) : (width_ff > DimW'(MaxDim)) ? DimW'(MaxDim) : width_ff;
      h_c = (height_ff == '0) ? DimW'(1) : (height_ff > DimW'(MaxDim)) ? DimW'(MaxDim) : height_ff;
      x_c = ({1'b0, req_data.pixel_x} > w_c - 1'b1) ? PixW'(w_c - 1'b1) : req_data.pixel_x;
      y_c = ({1'b0, req_data.pixel_y} > h_c - 1'b1) ? PixW'(h_c - 1'b1) : req_data.pixel_y;
      v_in[0] = $signed(VecW'({x_c, req_data.jitter_x})) -
         ($signed(VecW'({w_c, 7'd0})) - VecW'(128));
      v_in[1] = ($signed(VecW'({h_c, 7'd0})) - VecW'(128)) -
         $signed(VecW'({y_c, req_data.jitter_y}));
      v_in[2] = $signed(VecW'(focal_ff));
   end

   // stage 2: nine products
   logic signed [ProdW-1:0] p_ff [3][3];
   // stage 3: row sums
   logic signed [RotW-1:0] r_ff [3];
   // stage 4: magnitudes and top bit
   logic [MagW-1:0] a_ff [3];
   logic [2:0] neg_ff;
   logic [5:0] top_ff;
   logic zero_ff;
   // stage 5: normalized magnitudes
   logic [NrmW-1:0] n_ff [3];
   logic [2:0] neg5_ff;
   logic zero5_ff;
   // stage 6: sum of squares
   logic [SumW-1:0] sq_ff;
   logic [NrmW-1:0] n6_ff [3];
   logic [2:0] neg6_ff;
   logic zero6_ff;

   logic [MagW-1:0] a_in [3];
   logic [MagW-1:0] m_c;
   logic [5:0] top_in;
   logic [2*NrmW-1:0] sq_c [3];
   always_comb begin
      for (int i = 0; i < 3; i++) a_in[i] = r_ff[i][RotW-1] ? MagW'(-r_ff[i]) : MagW'(r_ff[i]);
      m_c = a_in[0] | a_in[1] | a_in[2];
      top_in = '0;
      for (int b = 0; b < MagW; b++) if (m_c[b]) top_in = 6'(b);
      for (int i = 0; i < 3; i++) sq_c[i] = n_ff[i] * n_ff[i];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) v_ff[i] <= v_in[i];
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               p_ff[i][j] <= ProdW'($signed(row_ff[i][16*j +: CoefW]) * v_ff[j]);
         for (int i = 0; i < 3; i++)
            r_ff[i] <= RotW'(p_ff[i][0]) + RotW'(p_ff[i][1]) + RotW'(p_ff[i][2]);
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= a_in[i];
            neg_ff[i] <= r_ff[i][RotW-1];
         end
         top_ff <= top_in;
         zero_ff <= (m_c == '0);
         for (int i = 0; i < 3; i++)
            n_ff[i] <= (top_ff > 6'd30) ? NrmW'(a_ff[i] >> (top_ff - 6'd30))
                                        : NrmW'(a_ff[i] << (6'd30 - top_ff));
         neg5_ff <= neg_ff;
         zero5_ff <= zero_ff;
         sq_ff <= SumW'(sq_c[0]) + SumW'(sq_c[1]) + SumW'(sq_c[2]);
         for (int i = 0; i < 3; i++) n6_ff[i] <= n_ff[i];
         neg6_ff <= neg5_ff;
         zero6_ff <= zero5_ff;
      end
   end

   // sqrt chain
   sqrt_word_type sw [SqrtCells+1];
   always_comb begin
      sw[0].rem = sq_ff;
      sw[0].root = '0;
      for (int i = 0; i < 3; i++) sw[0].mag[i] = n6_ff[i];
      sw[0].neg = neg6_ff;
      sw[0].degen = zero6_ff;
   end
   for (genvar g = 0; g < SqrtCells; g++) begin : g_sqrt
      crd_sqrt_cell u_cell (
         .clock(clock), .stall(!adv), .shift(6'(2 * (SqrtCells - 1 - g))),
         .word_in(sw[g]), .word_out(sw[g+1]));
   end

   // divide chain
   div_word_type dw [DivCells+1];
   logic [RootW-1:0] den_c;
   always_comb begin
      den_c = (sw[SqrtCells].root == '0) ? RootW'(1) : sw[SqrtCells].root;
      for (int i = 0; i < 3; i++) begin
         dw[0].rem[i] = {sw[SqrtCells].mag[i], 14'd0} + QuoNumW'(den_c >> 1);
         dw[0].quo[i] = '0;
      end
      dw[0].den = den_c;
      dw[0].neg = sw[SqrtCells].neg;
      dw[0].degen = sw[SqrtCells].degen;
   end
   for (genvar g = 0; g < DivCells; g++) begin : g_div
      crd_div_cell u_cell (
         .clock(clock), .stall(!adv), .shift(4'(DivCells - 1 - g)),
         .word_in(dw[g]), .word_out(dw[g+1]));
   end

   // output register with cap and sign
   rsp_type out_ff, out_in;
   logic [DirW-1:0] d_c [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_c[i] = (dw[DivCells].quo[i] > QuoW'(16384)) ? DirW'(16384)
                                                       : DirW'(dw[DivCells].quo[i]);
         if (dw[DivCells].neg[i]) d_c[i] = -d_c[i];
         if (dw[DivCells].degen) d_c[i] = '0;
      end
      out_in.dir_x = d_c[0];
      out_in.dir_y = d_c[1];
      out_in.dir_z = d_c[2];
      out_in.degenerate = dw[DivCells].degen;
   end
   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   assign rsp_valid = valid_ff[Depth-1];
   assign rsp_data = out_ff;

   `CRD_ASSERT_IMP(a_stall_iff_held, clock, reset, req_stall, rsp_valid && rsp_stall, "stall without held word")
   `CRD_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "held word changed")
   `CRD_ASSERT_IMP(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.dir_x == '0 && rsp_data.dir_y == '0 && rsp_data.dir_z == '0, "degenerate nonzero")
endmodule

FILE: verif/tb_camera_ray_direction_core.sv
module tb_camera_ray_direction_core;
   import crd_pkg::*;

   localparam int PipeDepth = 6 + SqrtCells + DivCells;
   localparam int NumRandom = 950;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0] csr_wdata;

   camera_ray_direction_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the camera registers
   logic [RowW-1:0] cam_row [3];
   logic [FocW-1:0] cam_focal;
   logic [12:0] cam_width;
   logic [12:0] cam_height;

   rsp_type ray_queue[$];
   int mismatches;
   bit failed;
   bit sender_busy;
   bit quiet_mode;
   bit hold_off;

   typedef struct {
      req_type word;
      bit known;
      rsp_type want;
   } vector_type;
   vector_type dir_table[$];

   function automatic longint coef_of(logic [RowW-1:0] row, int slot);
      logic signed [CoefW-1:0] c;
      c = row[16*slot +: 16];
      return longint'(c);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic rsp_type ray_direction(req_type w);
      longint wd, ht, px, py, vec[3], rot[3];
      longint unsigned a[3], m, n, sum, d;
      int top;
      rsp_type r;
      logic [DirW-1:0] comp[3];
      wd = (cam_width == 0) ? 1 : (cam_width > MaxDim ? MaxDim : cam_width);
      ht = (cam_height == 0) ? 1 : (cam_height > MaxDim ? MaxDim : cam_height);
      px = w.pixel_x;
      py = w.pixel_y;
      if (px > wd - 1) px = wd - 1;
      if (py > ht - 1) py = ht - 1;
      vec[0] = (px * 256 + w.jitter_x) - (wd * 128 - 128);
      vec[1] = (ht * 128 - 128) - (py * 256 + w.jitter_y);
      vec[2] = cam_focal;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         rot[i] = coef_of(cam_row[i], 0) * vec[0] + coef_of(cam_row[i], 1) * vec[1]
                  + coef_of(cam_row[i], 2) * vec[2];
         a[i] = rot[i] < 0 ? -rot[i] : rot[i];
         if (a[i] > m) m = a[i];
      end
      r = '0;
      if (m == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      top = 0;
      while (top < 63 && (m >> (top + 1)) != 0) top++;
      for (int i = 0; i < 3; i++) begin
         if (top > 30) a[i] >>= (top - 30);
         else a[i] <<= (30 - top);
      end
      sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      n = root_floor(sum);
      if (n == 0) n = 1;
      for (int i = 0; i < 3; i++) begin
         d = (a[i] * 16384 + n / 2) / n;
         if (d > 16384) d = 16384;
         if (rot[i] < 0) d = -d;
         comp[i] = d[15:0];
      end
      r.dir_x = comp[0];
      r.dir_y = comp[1];
      r.dir_z = comp[2];
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrW-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         RegRowX: cam_row[0] = val[RowW-1:0];
         RegRowY: cam_row[1] = val[RowW-1:0];
         RegRowZ: cam_row[2] = val[RowW-1:0];
         RegFocal: cam_focal = val[FocW-1:0];
         RegWidth: cam_width = val[12:0];
         RegHeight: cam_height = val[12:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (ray_queue.size() != 0) @(posedge clock);
      repeat (PipeDepth + 5) @(posedge clock);
   endtask

   task automatic send_word(req_type w, bit known, rsp_type want);
      rsp_type p;
      p = ray_direction(w);
      while (!quiet_mode && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (known && p !== want) begin
         failed = 1;
         $display("table row mismatch: table %h predictor %h", want, p);
      end
      ray_queue.push_back(p);
   endtask

   function automatic req_type rand_word(int wd, int ht);
      req_type w;
      w.pixel_x = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(wd));
      w.pixel_y = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(ht));
      w.jitter_x = 8'($urandom);
      w.jitter_y = 8'($urandom);
      return w;
   endfunction

   function automatic logic [RowW-1:0] rand_row();
      logic [RowW-1:0] r;
      r = {16'($urandom), 16'($urandom), 16'($urandom)};
      if ($urandom_range(3) == 0) r[16*$urandom_range(2) +: 16] = 16'h8000;
      return r;
   endfunction

   function automatic void add_row(logic [11:0] x, logic [11:0] y, logic [7:0] jx,
                                   logic [7:0] jy, bit known, rsp_type want);
      vector_type v;
      v.word = '{pixel_x: x, pixel_y: y, jitter_x: jx, jitter_y: jy};
      v.known = known;
      v.want = want;
      dir_table.push_back(v);
   endfunction

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) rsp_stall <= 1'b1;
         else if (quiet_mode) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(99) < 21);
      end
   end

   initial begin
      int hold_count;
      hold_off = 0;
      wait (sender_busy);
      repeat (40) @(posedge clock);
      hold_count = 0;
      hold_off = 1;
      while (hold_count < 200) begin
         @(posedge clock);
         hold_count++;
      end
      hold_off = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ray_queue.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_data);
         end else begin
            want = ray_queue.pop_front();
            if (rsp_data.dir_x !== want.dir_x || rsp_data.dir_y !== want.dir_y ||
                rsp_data.dir_z !== want.dir_z ||
                rsp_data.degenerate !== want.degenerate) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("ray mismatch: expected %0d %0d %0d %b got %0d %0d %0d %b",
                     want.dir_x, want.dir_y, want.dir_z, want.degenerate,
                     rsp_data.dir_x, rsp_data.dir_y, rsp_data.dir_z,
                     rsp_data.degenerate);
            end
         end
      end
   end

   initial begin
      rsp_type one_z, degen, none;
      int timeout;
      failed = 0;
      mismatches = 0;
      quiet_mode = 0;
      sender_busy = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_index <= RegRowX;
      csr_wdata <= '0;
      cam_row[0] = 48'd16384;
      cam_row[1] = 48'd1073741824;
      cam_row[2] = 48'd70368744177664;
      cam_focal = 24'd65536;
      cam_width = 13'd512;
      cam_height = 13'd512;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      one_z = '0;
      one_z.dir_z = 16'sd16384;
      degen = '0;
      degen.degenerate = 1'b1;
      none = '0;
      // center of a 512 image with default identity looks straight down z
      add_row(12'd255, 12'd255, 8'd128, 8'd128, 1, one_z);
      add_row(12'd0, 12'd0, 8'd0, 8'd0, 0, none);
      add_row(12'd511, 12'd511, 8'd255, 8'd255, 0, none);
      add_row(12'hfff, 12'hfff, 8'hff, 8'hff, 0, none);
      add_row(12'hfff, 12'd0, 8'd0, 8'hff, 0, none);
      add_row(12'd0, 12'hfff, 8'hff, 8'd0, 0, none);
      add_row(12'haaa, 12'h555, 8'haa, 8'h55, 0, none);
      add_row(12'h555, 12'haaa, 8'h55, 8'haa, 0, none);
      foreach (dir_table[i]) send_word(dir_table[i].word, dir_table[i].known, dir_table[i].want);
      drain();

      // zero focal and 1x1 image: zero vector without jitter
      write_reg(RegFocal, '0);
      write_reg(RegWidth, '0);
      write_reg(RegHeight, CsrW'(1));
      send_word('{pixel_x: 12'd0, pixel_y: 12'd0, jitter_x: 8'd0, jitter_y: 8'd0},
                1, degen);
      send_word('{pixel_x: 12'hfff, pixel_y: 12'hfff, jitter_x: 8'd0, jitter_y: 8'd0},
                1, degen);
      send_word('{pixel_x: 12'd3, pixel_y: 12'd0, jitter_x: 8'd0, jitter_y: 8'd255}, 0, none);
      drain();
      // oversized sizes clamp to the maximum, extreme focal and matrix
      write_reg(RegWidth, CsrW'(13'h1fff));
      write_reg(RegHeight, CsrW'(13'd4096));
      write_reg(RegFocal, CsrW'(24'hffffff));
      write_reg(RegRowX, 48'h8000_8000_8000);
      write_reg(RegRowY, 48'h7fff_7fff_7fff);
      write_reg(RegRowZ, 48'hffff_0001_8000);
      send_word('{pixel_x: 12'd0, pixel_y: 12'd0, jitter_x: 8'd0, jitter_y: 8'd0}, 0, none);
      send_word('{pixel_x: 12'hfff, pixel_y: 12'hfff, jitter_x: 8'hff, jitter_y: 8'hff},
                0, none);
      send_word('{pixel_x: 12'd2047, pixel_y: 12'd2048, jitter_x: 8'd128, jitter_y: 8'd0},
                0, none);
      drain();
      // zero matrix gives degenerate regardless of pixel
      write_reg(RegRowX, '0);
      write_reg(RegRowY, '0);
      write_reg(RegRowZ, '0);
      send_word('{pixel_x: 12'd77, pixel_y: 12'd9, jitter_x: 8'd1, jitter_y: 8'd2}, 1, degen);
      drain();

      sender_busy = 1;
      for (int phase = 0; phase < 8; phase++) begin
         int wd, ht, count;
         write_reg(RegRowX, rand_row());
         write_reg(RegRowY, rand_row());
         write_reg(RegRowZ, rand_row());
         write_reg(RegFocal, (phase % 3 == 0) ? CsrW'(24'($urandom))
                                              : CsrW'(24'($urandom_range(1 << 18))));
         wd = (phase == 2) ? 1 : (phase == 5 ? 4096 : $urandom_range(4096, 1));
         ht = (phase == 3) ? 1 : (phase == 5 ? 4096 : $urandom_range(4096, 1));
         write_reg(RegWidth, CsrW'(13'(wd)));
         write_reg(RegHeight, CsrW'(13'(ht)));
         quiet_mode = (phase == 4);
         count = NumRandom / 8;
         for (int k = 0; k < count; k++) send_word(rand_word(wd, ht), 0, none);
         quiet_mode = 0;
         drain();
      end

      timeout = 0;
      while (ray_queue.size() != 0 && timeout < 100000) begin
         @(posedge clock);
         timeout++;
      end
      repeat (PipeDepth + 10) @(posedge clock);
      if (!failed && ray_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: camera_ray_direction_core.f
+incdir+src
src/crd_pkg.sv
src/crd_sqrt_cell.sv
src/crd_div_cell.sv
src/camera_ray_direction_core.sv
verif/tb_camera_ray_direction_core.sv
